FILE: sv/aat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types, angle constants and the arctangent table for the tilt block.
// ----------------------------------------------------------------------------
package aat_pkg;

	localparam int AXIS_W   = 6;
	localparam int SQ_W     = 12;
	localparam int ANG_W    = 21;
	localparam int ANG_U_W  = 18;
	localparam int SCALE_W  = 23;
	localparam int STEPS    = 17;
	localparam int STEP_W   = 5;

	localparam logic signed [ANG_W-1:0] ANG_PI      = 21'sd205887;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 21'sd102944;
	localparam logic [SCALE_W-1:0] TILT_SCALE  = 23'd5319493;
	localparam logic [SCALE_W-1:0] PLANE_SCALE = 23'd3746693;
	localparam logic [8:0] TILT_CAP  = 9'd255;
	localparam logic [8:0] PLANE_CAP = 9'd179;

	typedef struct packed {
		logic                     busy;
		logic signed [AXIS_W-1:0] mean;
	} axis_res_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] angle;
	} cordic_res_t;

	function automatic logic [ANG_U_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [ANG_U_W-1:0] v;
		case (i)
			5'd0:    v = 18'd51472;
			5'd1:    v = 18'd30386;
			5'd2:    v = 18'd16055;
			5'd3:    v = 18'd8150;
			5'd4:    v = 18'd4091;
			5'd5:    v = 18'd2047;
			5'd6:    v = 18'd1024;
			5'd7:    v = 18'd512;
			5'd8:    v = 18'd256;
			5'd9:    v = 18'd128;
			5'd10:   v = 18'd64;
			5'd11:   v = 18'd32;
			5'd12:   v = 18'd16;
			5'd13:   v = 18'd8;
			5'd14:   v = 18'd4;
			5'd15:   v = 18'd2;
			5'd16:   v = 18'd1;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: sv/aat_axis_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_axis_lane
// One axis: ring window with running sum, mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module aat_axis_lane #(
	parameter int WINDOW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [7:0]       raw,
	output aat_pkg::axis_res_t    res
);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W  = 12;
	localparam int SH     = SUM_W + $clog2(WINDOW);
	localparam logic [SH:0] RECIP = (SH+1)'(((1 << SH) + WINDOW - 1) / WINDOW);
	localparam int PROD_W = SUM_W + SH + 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	logic signed [aat_pkg::AXIS_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0]                 vld_q;
	logic [SLOT_W-1:0]                 slot_q;
	logic signed [aat_pkg::AXIS_W-1:0] new_s1, old_s1;
	logic                              old_vld_s1;
	logic signed [SUM_W-1:0]           sum_q;
	logic [PROD_W-1:0]                 prod_s3;
	logic                              neg_s3;
	logic signed [aat_pkg::AXIS_W-1:0] mean_q;
	logic                              v_s1, v_s2, v_s3;
	logic signed [aat_pkg::AXIS_W-1:0] sample;
	logic [SUM_W-1:0]                  mag;
	logic [6:0]                        quo;

	assign sample = signed'(raw[5:0]);
	assign mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo    = prod_s3[SH +: 7];

	always_ff @(posedge clk) begin
		if (start) begin
			mem[slot_q] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			old_s1     <= mem[slot_q];
			old_vld_s1 <= vld_q[slot_q];
			new_s1     <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			slot_q <= '0;
			sum_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			mean_q <= '0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (start) begin
				vld_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
			// an unwritten slot counts as zero through its valid bit; the memory has no reset
			if (v_s1) begin
				sum_q <= sum_q + SUM_W'(new_s1)
					- (old_vld_s1 ? SUM_W'(old_s1) : '0);
			end
			if (v_s3) begin
				mean_q <= neg_s3 ? aat_pkg::AXIS_W'(7'd0 - quo) : aat_pkg::AXIS_W'(quo);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			prod_s3 <= PROD_W'(mag) * PROD_W'(RECIP);
			neg_s3  <= sum_q[SUM_W-1];
		end
	end

	assign res.busy = v_s1 | v_s2 | v_s3;
	assign res.mean = mean_q;

endmodule
`default_nettype wire

FILE: sv/aat_cordic_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_cordic_lane
// Iterative vectoring atan2 in Q16 radians, then scale and saturate.
// ----------------------------------------------------------------------------
module aat_cordic_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                tilt_sel,
	input  wire logic [aat_pkg::SQ_W-1:0]            ord,
	input  wire logic signed [aat_pkg::SQ_W-1:0]     absc,
	output aat_pkg::cordic_res_t                     res
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ITER = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;
	localparam int PROD_W = aat_pkg::ANG_U_W + aat_pkg::SCALE_W;

	logic [1:0]                           st_q;
	logic signed [31:0]                   x_q, y_q;
	logic signed [aat_pkg::ANG_W-1:0]     ang_q;
	logic [aat_pkg::STEP_W-1:0]           it_q;
	logic [PROD_W-1:0]                    prod_q;
	logic [7:0]                           angle_q;
	logic signed [31:0]                   xs, ys;
	logic signed [aat_pkg::ANG_W-1:0]     step_ang;
	logic [aat_pkg::ANG_U_W-1:0]          ang_c;
	logic [8:0]                           r, cap;

	assign xs       = x_q >>> it_q;
	assign ys       = y_q >>> it_q;
	assign step_ang = aat_pkg::ANG_W'(aat_pkg::atan_q16(it_q));
	assign cap      = tilt_sel ? aat_pkg::TILT_CAP : aat_pkg::PLANE_CAP;
	assign r        = prod_q[PROD_W-1:32];

	always_comb begin
		if (ang_q < 0)
			ang_c = '0;
		else if (ang_q > aat_pkg::ANG_PI)
			ang_c = aat_pkg::ANG_U_W'(aat_pkg::ANG_PI);
		else
			ang_c = aat_pkg::ANG_U_W'(ang_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			it_q    <= '0;
			angle_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						it_q <= '0;
						st_q <= (ord == '0) ? ST_MUL : ST_ITER;
					end
				end
				ST_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == aat_pkg::STEP_W'(aat_pkg::STEPS - 1))
						st_q <= ST_MUL;
				end
				ST_MUL: st_q <= ST_SAT;
				ST_SAT: begin
					angle_q <= (r > cap) ? cap[7:0] : r[7:0];
					st_q    <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			if (ord == '0) begin
				ang_q <= (absc < 0) ? aat_pkg::ANG_PI : '0;
			end else if (absc < 0) begin
				// pre-rotate by a quarter turn
				x_q   <= {4'd0, ord, 16'd0};
				y_q   <= 32'({-(13'(absc)), 16'd0});
				ang_q <= aat_pkg::ANG_HALF_PI;
			end else begin
				x_q   <= {{4{absc[aat_pkg::SQ_W-1]}}, absc, 16'd0};
				y_q   <= {4'd0, ord, 16'd0};
				ang_q <= '0;
			end
		end else if (st_q == ST_ITER) begin
			if (y_q > 0) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				ang_q <= ang_q + step_ang;
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				ang_q <= ang_q - step_ang;
			end
		end
		if (st_q == ST_MUL) begin
			prod_q <= PROD_W'(ang_c) * PROD_W'(tilt_sel ? aat_pkg::TILT_SCALE
				: aat_pkg::PLANE_SCALE);
		end
	end

	assign res.busy  = (st_q != ST_IDLE);
	assign res.angle = angle_q;

endmodule
`default_nettype wire

FILE: sv/accel_average_tilt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_average_tilt
// Windowed accelerometer averages with tilt and plane angles.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries raw_x, raw_y, raw_z; only bits 5..0
// of each byte count, as a signed sample. Output channel out_valid/out_ready
// carries the three window means and the two angles, one result per input.
// Three axis lanes update their windows and means in parallel (the mean is a
// reciprocal multiply), a square stage registers the squared means, then two
// CORDIC lanes run tilt and plane side by side: 17 iterations (none when the
// ordinate is zero) plus a scale multiply and saturation. One item is in work
// at a time: no new item is taken until the last one has gone to the output
// register. The output register lets the next item be accepted while a
// result waits; if the receiver stalls longer, the block holds its finished
// angles until out_ready frees the register.
// Reset clears all windows to zero (per-entry valid bits), the ring slot
// and the output valid flag.
// ----------------------------------------------------------------------------
module accel_average_tilt #(
	parameter int WINDOW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        raw_x,
	input  wire logic [7:0]        raw_y,
	input  wire logic [7:0]        raw_z,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [5:0]      x_average,
	output logic signed [5:0]      y_average,
	output logic signed [5:0]      z_average,
	output logic [7:0]             tilt_angle,
	output logic [7:0]             plane_angle
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_AVG  = 2'd1;
	localparam logic [1:0] ST_SQ   = 2'd2;
	localparam logic [1:0] ST_CORD = 2'd3;

	logic [1:0]                            st_q;
	logic                                  accept;
	aat_pkg::axis_res_t                    xr, yr, zr;
	aat_pkg::cordic_res_t                  tr, pr;
	logic [aat_pkg::SQ_W-1:0]              xy_q, pord_q;
	logic signed [aat_pkg::SQ_W-1:0]       zs_q, pabs_q;
	logic signed [5:0]                     xa_q, ya_q, za_q;
	logic signed [aat_pkg::SQ_W-1:0]       xsq, ysq, zsq;
	logic [6:0]                            xabs;
	logic                                  out_valid_q, load;

	assign in_ready = (st_q == ST_IDLE);
	assign accept   = in_valid & in_ready;

	aat_axis_lane #(.WINDOW(WINDOW)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .start(accept), .raw(raw_x), .res(xr));
	aat_axis_lane #(.WINDOW(WINDOW)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .start(accept), .raw(raw_y), .res(yr));
	aat_axis_lane #(.WINDOW(WINDOW)) u_lane_z (
		.clk(clk), .arst_n(arst_n), .start(accept), .raw(raw_z), .res(zr));

	assign xsq  = xr.mean * xr.mean;
	assign ysq  = yr.mean * yr.mean;
	assign zsq  = zr.mean * zr.mean;
	assign xabs = xr.mean[5] ? (7'd0 - {1'b1, xr.mean}) : {1'b0, xr.mean};

	always_ff @(posedge clk) begin
		if (st_q == ST_AVG && !(xr.busy | yr.busy | zr.busy)) begin
			xa_q   <= xr.mean;
			ya_q   <= yr.mean;
			za_q   <= zr.mean;
			xy_q   <= aat_pkg::SQ_W'(xsq + ysq);
			// a zero average counts as not positive
			zs_q   <= (zr.mean > 0) ? zsq : -zsq;
			pord_q <= aat_pkg::SQ_W'(xabs);
			pabs_q <= aat_pkg::SQ_W'(yr.mean);
		end
	end

	aat_cordic_lane u_cordic_tilt (
		.clk(clk), .arst_n(arst_n), .start(st_q == ST_SQ), .tilt_sel(1'b1),
		.ord(xy_q), .absc(zs_q), .res(tr));
	aat_cordic_lane u_cordic_plane (
		.clk(clk), .arst_n(arst_n), .start(st_q == ST_SQ), .tilt_sel(1'b0),
		.ord(pord_q), .absc(pabs_q), .res(pr));

	assign load = (st_q == ST_CORD) && !(tr.busy | pr.busy) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (accept) st_q <= ST_AVG;
				ST_AVG:  if (!(xr.busy | yr.busy | zr.busy)) st_q <= ST_SQ;
				ST_SQ:   st_q <= ST_CORD;
				ST_CORD: if (load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_average   <= xa_q;
			y_average   <= ya_q;
			z_average   <= za_q;
			tilt_angle  <= tr.angle;
			plane_angle <= pr.angle;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: sv/aat_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aat_checker
// Port-level checks on the tilt block, bound to the top level.
// ----------------------------------------------------------------------------
module aat_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  x_average,
	input wire logic [7:0]  tilt_angle,
	input wire logic [7:0]  plane_angle
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tilt_angle)
			&& $stable(plane_angle) && $stable(x_average))
		else $error("stalled result changed");

	// one transaction in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a result never rises straight after accept
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	a_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> plane_angle <= 8'd179)
		else $error("plane angle out of range");

endmodule

bind accel_average_tilt aat_checker u_aat_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .x_average(x_average),
	.tilt_angle(tilt_angle), .plane_angle(plane_angle));
`default_nettype wire

FILE: dv/accel_average_tilt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_average_tilt_checker
// Watches both channels of the tilt block, predicts each result from the
// accepted raw samples and compares every output transaction field by field.
// ----------------------------------------------------------------------------
module accel_average_tilt_checker #(
	parameter int WINDOW = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  raw_x,
	input  wire logic [7:0]  raw_y,
	input  wire logic [7:0]  raw_z,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [5:0]  x_average,
	input  wire logic [5:0]  y_average,
	input  wire logic [5:0]  z_average,
	input  wire logic [7:0]  tilt_angle,
	input  wire logic [7:0]  plane_angle,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [5:0] xa;
		logic [5:0] ya;
		logic [5:0] za;
		logic [7:0] tilt;
		logic [7:0] plane;
	} sample_res_t;

	sample_res_t expected_q[$];
	int          x_hist[WINDOW];
	int          y_hist[WINDOW];
	int          z_hist[WINDOW];
	int          slot;

	function automatic int sign6(input logic [7:0] raw);
		return int'($signed(raw[5:0]));
	endfunction

	function automatic longint arctan_q16(input longint ord, input longint absc);
		longint tbl[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		longint vx, vy, ang, nx, ny;
		if (ord == 0)
			return (absc < 0) ? 205887 : 0;
		vx = absc * 65536;
		vy = ord * 65536;
		ang = 0;
		if (vx < 0) begin
			nx = vy;
			vy = -vx;
			vx = nx;
			ang = 102944;
		end
		for (int i = 0; i < 17; i++) begin
			// arithmetic shift is a floor on negatives
			if (vy > 0) begin
				nx = vx + (vy >>> i);
				ny = vy - (vx >>> i);
				ang += tbl[i];
			end else begin
				nx = vx - (vy >>> i);
				ny = vy + (vx >>> i);
				ang -= tbl[i];
			end
			vx = nx;
			vy = ny;
		end
		if (ang < 0) ang = 0;
		if (ang > 205887) ang = 205887;
		return ang;
	endfunction

	function automatic logic [7:0] scaled_angle(input longint ang, input longint scale,
			input longint cap);
		longint r;
		r = (ang * scale) >>> 32;
		return (r > cap) ? cap[7:0] : r[7:0];
	endfunction

	function automatic int window_mean(input int h[WINDOW]);
		int sum;
		sum = 0;
		foreach (h[i]) sum += h[i];
		return sum / WINDOW;
	endfunction

	task automatic predict_sample();
		int xa, ya, za;
		longint xy, zs;
		sample_res_t r;
		x_hist[slot] = sign6(raw_x);
		y_hist[slot] = sign6(raw_y);
		z_hist[slot] = sign6(raw_z);
		slot = (slot + 1) % WINDOW;
		xa = window_mean(x_hist);
		ya = window_mean(y_hist);
		za = window_mean(z_hist);
		xy = xa * xa + ya * ya;
		zs = za * za;
		if (za <= 0) zs = -zs;
		r.xa = xa[5:0];
		r.ya = ya[5:0];
		r.za = za[5:0];
		r.tilt = scaled_angle(arctan_q16(xy, zs), 5319493, 255);
		r.plane = scaled_angle(arctan_q16((xa < 0) ? -xa : xa, ya), 3746693, 179);
		expected_q.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		slot = 0;
		foreach (x_hist[i]) begin
			x_hist[i] = 0;
			y_hist[i] = 0;
			z_hist[i] = 0;
		end
	end

	assign pending = expected_q.size();

	always @(posedge clk) begin
		sample_res_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					e = expected_q.pop_front();
					if (x_average !== e.xa)
						report_mismatch("x_average", $signed(x_average), $signed(e.xa));
					if (y_average !== e.ya)
						report_mismatch("y_average", $signed(y_average), $signed(e.ya));
					if (z_average !== e.za)
						report_mismatch("z_average", $signed(z_average), $signed(e.za));
					if (tilt_angle !== e.tilt)
						report_mismatch("tilt_angle", tilt_angle, e.tilt);
					if (plane_angle !== e.plane)
						report_mismatch("plane_angle", plane_angle, e.plane);
				end
			end
			if (in_valid && in_ready)
				predict_sample();
		end
	end

endmodule

FILE: dv/accel_average_tilt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_average_tilt_tb
// Drives directed and random raw samples through the tilt block under
// several sender and receiver idling mixes; the checker predicts results.
// ----------------------------------------------------------------------------
module accel_average_tilt_tb;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] raw_x, raw_y, raw_z;
	logic       out_valid;
	logic       out_ready;
	logic [5:0] x_average, y_average, z_average;
	logic [7:0] tilt_angle, plane_angle;
	int         fail_count;
	int         pending;
	int         send_idle_pct;
	int         recv_stall_pct;
	longint     cycle_count;

	accel_average_tilt #(.WINDOW(8)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_average(x_average), .y_average(y_average), .z_average(z_average),
		.tilt_angle(tilt_angle), .plane_angle(plane_angle)
	);

	accel_average_tilt_checker #(.WINDOW(8)) i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_average(x_average), .y_average(y_average), .z_average(z_average),
		.tilt_angle(tilt_angle), .plane_angle(plane_angle),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous limit: ~1000 items with heavy stalls
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid drops only when the sender idles, so it gets one update per edge
	task automatic send_sample(input logic [7:0] bx, input logic [7:0] by,
			input logic [7:0] bz);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_x <= bx;
		raw_y <= by;
		raw_z <= bz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// a steady tilt: one to twelve samples near one vector with random noise and top bits
	task automatic send_burst(output int n);
		int bx, by, bz;
		bx = $urandom_range(63);
		by = $urandom_range(63);
		bz = $urandom_range(63);
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++)
			send_sample({2'($urandom), 6'(bx + $urandom_range(2) - 1)},
				{2'($urandom), 6'(by + $urandom_range(2) - 1)},
				{2'($urandom), 6'(bz + $urandom_range(2) - 1)});
	endtask

	initial begin
		int sent;
		int nb;
		in_valid = 1'b0;
		raw_x = '0;
		raw_y = '0;
		raw_z = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero window: both operands zero, then extremes of each axis
		send_sample(8'h00, 8'h00, 8'h00);
		for (int i = 0; i < 8; i++) send_sample(8'h1F, 8'h00, 8'h00);
		for (int i = 0; i < 8; i++) send_sample(8'hE0, 8'h20, 8'hFF);
		send_sample(8'h00, 8'h1F, 8'h20);
		send_sample(8'h3F, 8'hC0, 8'h1F);
		send_sample(8'hFF, 8'hFF, 8'h9F);
		send_sample(8'h60, 8'h7F, 8'h5F);
		send_sample(8'hA5, 8'h5A, 8'h00);

		sent = 0;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				3: begin send_idle_pct = 30; recv_stall_pct = 30; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			while (sent < (phase + 1) * 200) begin
				if ($urandom_range(99) < 75) begin
					send_burst(nb);
					sent = sent + nb;
				end else begin
					send_sample(8'($urandom), 8'($urandom), 8'($urandom));
					sent = sent + 1;
				end
			end
		end
		in_valid <= 1'b0;

		recv_stall_pct = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/aat_pkg.sv
sv/aat_axis_lane.sv
sv/aat_cordic_lane.sv
sv/accel_average_tilt.sv
sv/aat_checker.sv
dv/accel_average_tilt_checker.sv
dv/accel_average_tilt_tb.sv
